// ===== design/frame_bitmap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Shared forms for the concurrent checks of the frame allocator.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Check that is ignored while the synchronous reset is asserted.
`define FBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds on the reset edges themselves.
`define FBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame allocator package
// Command and status codes, and the sizing constants of the frame bitmap.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int FRAMES_DEFAULT = 1024;
    localparam int FRAMES_MAX     = 4096;
    localparam int WORD_BITS      = 32;
    localparam int CHUNK_WORDS    = 16;
    localparam int IDX_W          = 12;
    localparam int CNT_W          = 13;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ===== design/fba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/frame_bitmap_allocator.sv =====
// Allocate steps through the find, pick and modify states from the accepted beat
// to the result beat, free and test through read and modify, and the no-op and
// range or full rejections go straight to modify; modify waits for a free output.
// One request at a time: the next beat is taken once the result is in the output
// register. Allocate and free read-modify-write one 32-bit bitmap word in the RAM.
// Reset clears the word valid and word full bits at once: no clearing pass.
// ----------------------------------------------------------------------------
// Bitmap first-fit frame allocator
// Keeps one used bit per frame in a word RAM, grants the lowest free frame,
// frees and tests frames, and reports the free count with every result.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_assert.svh"

module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] frame_index, [15:12] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [11:0] frame_out, [12] in_use,
                                     // [25:13] free_count, [31:26] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int WORDS     = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NCH       = (WORDS + CHUNK_WORDS - 1) / CHUNK_WORDS;
    localparam int CW        = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int LAST_BITS = FRAMES - (WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD =
        (LAST_BITS == WORD_BITS) ? '0 : ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
    localparam logic [WA-1:0]    LAST_WORD = WA'(WORDS - 1);
    localparam logic [CNT_W-1:0] FRAMES_C  = CNT_W'(FRAMES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIND = 5'b00010,
        S_PICK = 5'b00100,
        S_READ = 5'b01000,
        S_MOD  = 5'b10000
    } t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_none;
    logic                   r_oor;
    logic [WA-1:0]          r_addr;
    logic [NCH-1:0]         r_chunk_free;
    logic [WORDS-1:0]       r_full;
    logic [WORDS-1:0]       r_wvalid;
    logic [CNT_W-1:0]       r_free_cnt;

    logic                   r_m_valid;
    t_status                r_m_status;
    logic [IDX_W-1:0]       r_m_frame;
    logic                   r_m_in_use;
    logic [CNT_W-1:0]       r_m_cnt;

    logic                   s_accept;
    t_cmd                   in_cmd;
    logic [IDX_W-1:0]       in_idx;
    logic                   out_free;
    logic                   commit;

    logic [NCH*CHUNK_WORDS-1:0] full_pad;
    logic [CW-1:0]          pick_chunk;
    logic [CHUNK_WORDS-1:0] pick_slice;
    logic [3:0]             pick_word;
    logic [WA-1:0]          pick_addr;

    logic                   ram_re;
    logic [WA-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic                   ram_we;
    logic [WORD_BITS-1:0]   ram_wdata;

    logic [WORD_BITS-1:0]   cur_word;
    logic [4:0]             zero_bit;
    logic [4:0]             idx_bit;
    logic [WORD_BITS-1:0]   new_word;

    t_status                n_status;
    logic [IDX_W-1:0]       n_frame;
    logic                   n_in_use;
    logic [CNT_W-1:0]       n_cnt;
    logic                   n_full_set;
    logic                   n_full_clr;

    assign in_cmd   = t_cmd'(i_s_tuser);
    assign in_idx   = i_s_tdata[IDX_W-1:0];
    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;
    assign commit   = (r_state == S_MOD) && out_free;
    assign idx_bit  = r_idx[4:0];

    // Words past the end of the map count as full so the search skips them.
    always_comb begin
        full_pad = '1;
        full_pad[WORDS-1:0] = r_full;
    end

    // Second level of the search: first chunk with a free word, then the
    // first free word inside that chunk.
    always_comb begin
        pick_chunk = '0;
        for (int c = NCH - 1; c >= 0; c--) begin
            if (r_chunk_free[c]) begin
                pick_chunk = CW'(c);
            end
        end
        pick_slice = full_pad[pick_chunk*CHUNK_WORDS +: CHUNK_WORDS];
        pick_word  = '0;
        for (int j = CHUNK_WORDS - 1; j >= 0; j--) begin
            if (!pick_slice[j]) begin
                pick_word = 4'(j);
            end
        end
        pick_addr = WA'({pick_chunk, pick_word});
    end

    assign ram_re    = (r_state == S_PICK) || (r_state == S_READ);
    assign ram_raddr = (r_state == S_PICK) ? pick_addr : r_addr;

    // A word never written reads as all free; padding frames read as used.
    always_comb begin
        cur_word = r_wvalid[r_addr] ? ram_rdata : '0;
        if (r_addr == LAST_WORD) begin
            cur_word = cur_word | PAD;
        end
        zero_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!cur_word[b]) begin
                zero_bit = 5'(b);
            end
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_frame    = r_idx;
        n_in_use   = 1'b0;
        n_cnt      = r_free_cnt;
        new_word   = cur_word;
        ram_we     = 1'b0;
        n_full_set = 1'b0;
        n_full_clr = 1'b0;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (r_none) begin
                    n_status = ST_FULL;
                    n_frame  = '0;
                end else begin
                    new_word            = cur_word;
                    new_word[zero_bit]  = 1'b1;
                    n_frame             = IDX_W'({r_addr, zero_bit});
                    n_cnt               = r_free_cnt - CNT_W'(1);
                    ram_we              = commit;
                    n_full_set          = (new_word == '1);
                end
            end
            CMD_FREE: begin
                if (r_oor) begin
                    n_status = ST_RANGE;
                end else if (cur_word[idx_bit]) begin
                    new_word          = cur_word;
                    new_word[idx_bit] = 1'b0;
                    n_cnt             = r_free_cnt + CNT_W'(1);
                    ram_we            = commit;
                    n_full_clr        = 1'b1;
                end
            end
            CMD_TEST: begin
                if (r_oor) begin
                    n_status = ST_RANGE;
                end else begin
                    n_in_use = cur_word[idx_bit];
                end
            end
            CMD_NOP: begin
                n_status = ST_OK;
            end
        endcase
        ram_wdata = new_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_full     <= '0;
            r_wvalid   <= '0;
            r_free_cnt <= FRAMES_C;
            r_m_valid  <= 1'b0;
        end else begin
            if (commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        if (in_cmd == CMD_ALLOC && r_free_cnt != '0) begin
                            r_state <= S_FIND;
                        end else if ((in_cmd == CMD_FREE || in_cmd == CMD_TEST)
                                     && ({1'b0, in_idx} < FRAMES_C)) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_FIND: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_state <= S_MOD;
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (commit) begin
                        r_state    <= S_IDLE;
                        r_free_cnt <= n_cnt;
                        if (ram_we) begin
                            r_wvalid[r_addr] <= 1'b1;
                        end
                        if (n_full_set) begin
                            r_full[r_addr] <= 1'b1;
                        end
                        if (n_full_clr) begin
                            r_full[r_addr] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd  <= in_cmd;
            r_idx  <= in_idx;
            r_none <= (r_free_cnt == '0);
            r_oor  <= ({1'b0, in_idx} >= FRAMES_C);
            r_addr <= WA'(in_idx >> 5);
        end else if (r_state == S_PICK) begin
            r_addr <= pick_addr;
        end
        if (r_state == S_FIND) begin
            for (int c = 0; c < NCH; c++) begin
                r_chunk_free[c] <= ~&full_pad[c*CHUNK_WORDS +: CHUNK_WORDS];
            end
        end
        if (commit) begin
            r_m_status <= n_status;
            r_m_frame  <= n_frame;
            r_m_in_use <= n_in_use;
            r_m_cnt    <= n_cnt;
        end
    end

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WA)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {6'd0, r_m_cnt, r_m_in_use, r_m_frame};

    `FBA_ASSERT(a_cnt_bound, (r_free_cnt <= FRAMES_C), "free count above frame total")
    `FBA_ASSERT(a_we_in_mod, (ram_we |-> r_state == S_MOD), "bitmap write outside update")
    `FBA_ASSERT(a_find_alloc, ((r_state == S_FIND) |-> (r_cmd == CMD_ALLOC && !r_none)),
        "search started without a grantable allocate")
    `FBA_ASSERT(a_alloc_dec,
        ((commit && r_cmd == CMD_ALLOC && !r_none) |=> r_free_cnt == $past(r_free_cnt) - 1),
        "allocate did not lower the free count")
    `FBA_ASSERT_ALWAYS(a_rst_idle, (!i_rst_n |=> r_state == S_IDLE && !r_m_valid),
        "reset did not idle the allocator")

endmodule
